FILE: hdl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared widths, defaults and codes for the histogram with peak and range sum.
// ----------------------------------------------------------------------------
`default_nettype none

package hps_pkg;

  // default geometry of the bin store
  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 20;

  // fixed field widths
  localparam int VALUE_W    = 8;
  localparam int TOTAL_W    = 32;
  localparam int RANGE_W    = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;

  // request kinds carried on tuser
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/histogram_with_peak_and_range_sum.sv
// ----------------------------------------------------------------------------
// histogram_with_peak_and_range_sum
// Histogram of 8-bit values in a bin memory with peak bin, largest value,
// saturated running total and inclusive bin range sums.
// ----------------------------------------------------------------------------
// record: read the bin, then write back and load the result when the output is free
// query: reads each bin in the range after clipping to the store,
//   one bin read per cycle through the single read port
// an empty range or a value outside the store answers without a bin read
// one request at a time; a new request is taken while the last result waits
// reset: a clearing pass zeroes every bin, no request taken
`default_nettype none

module histogram_with_peak_and_range_sum #(
  parameter int NUM_BINS    = hps_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = hps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // sample_value [7:0], query_low [15:8], query_high [23:16]
  input  wire logic [hps_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // range_count [31:0], peak_bin [39:32], largest_value [47:40],
  // weight_total [79:48], is_empty [80], zero [87:81]
  output logic      [hps_pkg::OUT_DATA_W-1:0]  m_tdata
);

  import hps_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_REC  = 3'd2;
  localparam logic [2:0] ST_QRY  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state, state_next;
  logic [AW-1:0]          clr_addr, clr_addr_next;
  logic [AW-1:0]          q_addr, q_addr_next;
  logic [AW-1:0]          q_hi, q_hi_next;
  logic                   q_last, q_last_next;
  logic [VALUE_W-1:0]     q_value, q_value_next;
  logic [RANGE_W-1:0]     acc, acc_next;
  logic [VALUE_W-1:0]     peak_index, peak_index_next;
  logic [COUNT_WIDTH-1:0] peak_count, peak_count_next;
  logic [VALUE_W-1:0]     max_seen, max_seen_next;
  logic [TOTAL_W-1:0]     running_total, running_total_next;
  logic                   any_recorded, any_recorded_next;

  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [COUNT_WIDTH-1:0] wr_data, rd_data;

  logic                   accept, out_free, out_load;
  logic [31:0]            sv_ext, lo_ext, hi_ext, hi_clip;
  logic                   range_ok;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [RANGE_W:0]       acc_sum;
  logic [RANGE_W-1:0]     acc_sat;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_sat;

  hps_bin_ram #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_WIDTH)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // handshake
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // request fields widened for range checks against the store size
  assign sv_ext   = 32'(s_tdata[7:0]);
  assign lo_ext   = 32'(s_tdata[15:8]);
  assign hi_ext   = 32'(s_tdata[23:16]);
  assign hi_clip  = (hi_ext >= 32'(NUM_BINS)) ? 32'(NUM_BINS - 1) : hi_ext;
  assign range_ok = (lo_ext < 32'(NUM_BINS)) && (lo_ext <= hi_clip);

  // saturating bin increment, range accumulate and total
  assign new_cnt   = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;
  assign acc_sum   = {1'b0, acc} + (RANGE_W + 1)'(rd_data);
  assign acc_sat   = acc_sum[RANGE_W] ? {RANGE_W{1'b1}} : acc_sum[RANGE_W-1:0];
  assign total_sum = {1'b0, running_total} + (TOTAL_W + 1)'(q_value);
  assign total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  // sequencer: clear pass, bin read-modify-write, range walk
  always_comb begin
    state_next         = state;
    clr_addr_next      = clr_addr;
    q_addr_next        = q_addr;
    q_hi_next          = q_hi;
    q_last_next        = q_last;
    q_value_next       = q_value;
    acc_next           = acc;
    peak_index_next    = peak_index;
    peak_count_next    = peak_count;
    max_seen_next      = max_seen;
    running_total_next = running_total;
    any_recorded_next  = any_recorded;
    rd_en              = 1'b0;
    rd_addr            = q_addr;
    wr_en              = 1'b0;
    wr_addr            = clr_addr;
    wr_data            = '0;
    out_load           = 1'b0;
    case (state)
      ST_CLR: begin
        wr_en = 1'b1;
        if (clr_addr == LAST_BIN) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          acc_next = '0;
          if (s_tuser == MODE_RECORD) begin
            q_value_next = s_tdata[7:0];
            q_addr_next  = sv_ext[AW-1:0];
            if (sv_ext < 32'(NUM_BINS)) begin
              rd_en      = 1'b1;
              rd_addr    = sv_ext[AW-1:0];
              state_next = ST_REC;
            end else begin
              state_next = ST_FIN;
            end
          end else if (range_ok) begin
            rd_en       = 1'b1;
            rd_addr     = lo_ext[AW-1:0];
            q_addr_next = lo_ext[AW-1:0] + 1'b1;
            q_hi_next   = hi_clip[AW-1:0];
            q_last_next = (lo_ext[AW-1:0] == hi_clip[AW-1:0]);
            state_next  = ST_QRY;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_REC: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = q_addr;
          wr_data = new_cnt;
          // strict compare keeps the earlier peak on a tie
          if (!any_recorded || (new_cnt > peak_count) || (q_value == peak_index)) begin
            peak_index_next = q_value;
            peak_count_next = new_cnt;
          end
          if (!any_recorded || (q_value > max_seen)) begin
            max_seen_next = q_value;
          end
          running_total_next = total_sat;
          any_recorded_next  = 1'b1;
          out_load           = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      ST_QRY: begin
        acc_next = acc_sat;
        if (q_last) begin
          state_next = ST_FIN;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = q_addr;
          q_addr_next = q_addr + 1'b1;
          q_last_next = (q_addr == q_hi);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_addr      <= '0;
      peak_index    <= '0;
      peak_count    <= '0;
      max_seen      <= '0;
      running_total <= '0;
      any_recorded  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      peak_index    <= peak_index_next;
      peak_count    <= peak_count_next;
      max_seen      <= max_seen_next;
      running_total <= running_total_next;
      any_recorded  <= any_recorded_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request payload and result register
  always_ff @(posedge clk) begin
    q_addr  <= q_addr_next;
    q_hi    <= q_hi_next;
    q_last  <= q_last_next;
    q_value <= q_value_next;
    acc     <= acc_next;
    if (out_load) begin
      m_tdata <= {7'b0, !any_recorded_next, running_total_next, max_seen_next,
                  peak_index_next, acc_next};
    end
  end

  // an empty histogram reports zero peak, largest value and total
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[80]) |-> (m_tdata[47:32] == '0 && m_tdata[79:48] == '0))
    else $error("empty result carries nonzero peak, largest value or total");

  // nothing recorded means no peak count and no total
  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    !any_recorded |-> (peak_count == '0 && running_total == '0 && peak_index == '0))
    else $error("histogram state set without a record");

  // the bin memory never reads and writes in the same cycle
  a_port_use: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("bin memory read and write collide");

  // a record in range writes back to the bin it read, never straight after the clear pass
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REC && wr_en) |-> (wr_addr == q_addr && $past(state) != ST_CLR))
    else $error("bin write back out of order");

endmodule

`default_nettype wire

FILE: hdl/hps_bin_ram.sv
// ----------------------------------------------------------------------------
// hps_bin_ram
// Simple dual-port bin store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_bin_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: verif/histogram_with_peak_and_range_sum_tb.sv
// ----------------------------------------------------------------------------
// histogram_with_peak_and_range_sum_tb
// Self-checking bench: a queue-fed stream driver sends record and range query
// requests, a scoreboard keeps its own bin store, peak, largest value and
// total, and a monitor compares every result field against it while both
// sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module histogram_with_peak_and_range_sum_tb;
  import hps_pkg::*;

  localparam int BATCH_SIZE     = 50;
  localparam int BATCHES        = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam logic [COUNT_WIDTH_DEF-1:0] BIN_FULL   = '1;
  localparam logic [TOTAL_W-1:0]         TOTAL_FULL = '1;
  localparam logic [RANGE_W-1:0]         RANGE_FULL = '1;

  // one request as seen on the slave side
  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] sample_value;
    logic [VALUE_W-1:0] query_low;
    logic [VALUE_W-1:0] query_high;
  } hist_req_t;

  // one result as seen on the master side
  typedef struct packed {
    logic [RANGE_W-1:0] range_count;
    logic [VALUE_W-1:0] peak_bin;
    logic [VALUE_W-1:0] largest_value;
    logic [TOTAL_W-1:0] weight_total;
    logic               is_empty;
  } hist_res_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = MODE_RECORD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  histogram_with_peak_and_range_sum uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // scoreboard copy of the histogram state
  logic [COUNT_WIDTH_DEF-1:0] bin_count [NUM_BINS_DEF];
  logic [VALUE_W-1:0]         peak_idx;
  logic [VALUE_W-1:0]         max_val;
  logic [TOTAL_W-1:0]         run_total;
  logic                       seen_any;

  hist_req_t    pending_q[$];
  hist_res_t    expected_q[$];
  hist_req_t    req_in_flight;
  logic [7:0]   hot_vals [8];
  int           queued_cnt     = 0;
  int           accepted_cnt   = 0;
  int           fail_cnt       = 0;
  int           idle_cycles    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // apply one request to the scoreboard state and return the result it gives
  function automatic hist_res_t apply_request(input hist_req_t req);
    hist_res_t  res;
    logic [63:0] acc;
    int         v;
    res = '0;
    if (req.mode == MODE_RECORD) begin
      v = int'(req.sample_value);
      if (v < NUM_BINS_DEF) begin
        if (bin_count[v] != BIN_FULL) bin_count[v] = bin_count[v] + 1'b1;
        // strict compare keeps the earlier peak on a tie
        if (!seen_any || bin_count[v] > bin_count[peak_idx]) peak_idx = req.sample_value;
        if (!seen_any || req.sample_value > max_val) max_val = req.sample_value;
        acc = 64'(run_total) + 64'(req.sample_value);
        run_total = (acc > 64'(TOTAL_FULL)) ? TOTAL_FULL : acc[TOTAL_W-1:0];
        seen_any = 1'b1;
      end
    end else begin
      acc = '0;
      for (int i = int'(req.query_low); i <= int'(req.query_high); i++) begin
        if (i < NUM_BINS_DEF) acc += 64'(bin_count[i]);
      end
      res.range_count = (acc > 64'(RANGE_FULL)) ? RANGE_FULL : acc[RANGE_W-1:0];
    end
    res.peak_bin      = peak_idx;
    res.largest_value = max_val;
    res.weight_total  = run_total;
    res.is_empty      = !seen_any;
    return res;
  endfunction

  // random request, mostly short ranges, half the values from a small hot set
  function automatic hist_req_t random_request();
    hist_req_t req;
    int        sel;
    int        top;
    req.mode         = ($urandom_range(99) < 60) ? MODE_RECORD : MODE_QUERY;
    req.sample_value = ($urandom_range(1) == 0) ? hot_vals[$urandom_range(7)]
                                                : 8'($urandom_range(255));
    req.query_low    = 8'($urandom_range(255));
    sel = $urandom_range(99);
    if (sel < 75) begin
      top = int'(req.query_low) + $urandom_range(7);
      req.query_high = (top > 255) ? 8'd255 : 8'(top);
    end else if (sel < 85) begin
      // reversed range
      if (req.query_low == 8'd0) req.query_low = 8'($urandom_range(255, 1));
      req.query_high = 8'($urandom_range(int'(req.query_low) - 1));
    end else if (sel < 92) begin
      req.query_high = req.query_low;
    end else if (sel < 96) begin
      req.query_low  = 8'($urandom_range(15));
      req.query_high = 8'($urandom_range(255, 200));
    end else begin
      req.query_low  = 8'd0;
      req.query_high = 8'd255;
    end
    return req;
  endfunction

  task automatic queue_request(input logic mode, input logic [7:0] sv,
                               input logic [7:0] lo, input logic [7:0] hi);
    hist_req_t req;
    req.mode         = mode;
    req.sample_value = sv;
    req.query_low    = lo;
    req.query_high   = hi;
    pending_q.insert(pending_q.size(), req);
    queued_cnt++;
  endtask

  // hold off until every queued request is taken and every result is back
  task automatic wait_all_done();
    while (accepted_cnt != queued_cnt || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.insert(expected_q.size(), apply_request(req_in_flight));
        accepted_cnt++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until taken
      end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_in_flight = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {req_in_flight.query_high, req_in_flight.query_low,
                     req_in_flight.sample_value};
        s_tuser  <= req_in_flight.mode;
      end else begin
        s_tvalid <= 1'b0;
        s_tdata  <= IN_DATA_W'($urandom);
        s_tuser  <= 1'($urandom_range(1));
      end
    end
  end

  // result monitor and scoreboard compare
  always @(posedge clk) begin
    hist_res_t got;
    hist_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.range_count   = m_tdata[31:0];
        got.peak_bin      = m_tdata[39:32];
        got.largest_value = m_tdata[47:40];
        got.weight_total  = m_tdata[79:48];
        got.is_empty      = m_tdata[80];
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("range_count", 64'(want.range_count), 64'(got.range_count));
          check_field("peak_bin", 64'(want.peak_bin), 64'(got.peak_bin));
          check_field("largest_value", 64'(want.largest_value), 64'(got.largest_value));
          check_field("weight_total", 64'(want.weight_total), 64'(got.weight_total));
          check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    for (int i = 0; i < NUM_BINS_DEF; i++) bin_count[i] = '0;
    peak_idx  = '0;
    max_val   = '0;
    run_total = '0;
    seen_any  = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, peak ties, extremes, reversed and point ranges
    @(negedge clk);
    queue_request(MODE_QUERY,  8'h00, 8'd0,   8'd255);
    queue_request(MODE_QUERY,  8'h00, 8'd0,   8'd0);
    queue_request(MODE_QUERY,  8'h00, 8'd255, 8'd0);
    queue_request(MODE_RECORD, 8'd0,   8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd255, 8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd128, 8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd255, 8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd0,   8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd0,   8'h00, 8'h00);
    queue_request(MODE_RECORD, 8'd1,   8'hff, 8'hff);
    queue_request(MODE_QUERY,  8'hff, 8'd0,   8'd0);
    queue_request(MODE_QUERY,  8'h00, 8'd255, 8'd255);
    queue_request(MODE_QUERY,  8'h00, 8'd0,   8'd255);
    queue_request(MODE_QUERY,  8'h00, 8'd254, 8'd255);
    queue_request(MODE_QUERY,  8'h00, 8'd10,  8'd5);
    queue_request(MODE_QUERY,  8'h00, 8'd128, 8'd128);
    queue_request(MODE_QUERY,  8'h00, 8'd1,   8'd254);
    queue_request(MODE_RECORD, 8'haa, 8'h55, 8'haa);
    queue_request(MODE_RECORD, 8'h55, 8'haa, 8'h55);
    queue_request(MODE_QUERY,  8'h55, 8'h55, 8'haa);
    wait_all_done();

    // random phases with different idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct = 36; recv_stall_pct = 36;
        end
      endcase
      for (int h = 0; h < 8; h++) hot_vals[h] = 8'($urandom_range(255));
      hot_vals[0] = (ph[0]) ? 8'd255 : 8'd0;
      // batches separated by a full drain of outstanding results
      for (int b = 0; b < BATCHES; b++) begin
        @(negedge clk);
        repeat (BATCH_SIZE) begin
          pending_q.insert(pending_q.size(), random_request());
          queued_cnt++;
        end
        wait_all_done();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: histogram_with_peak_and_range_sum.f
hdl/hps_pkg.sv
hdl/hps_bin_ram.sv
hdl/histogram_with_peak_and_range_sum.sv
verif/histogram_with_peak_and_range_sum_tb.sv
